>>> sv/lp2m_pkg.sv
// shared constants for the lidar polar to map conversion pipeline
package lp2m_pkg;

   // default fraction bits of the sine and cosine values
   localparam int TRIG_FRAC_BITS_DEF = 15;

   // angle layout: two quadrant bits above a 14-bit phase
   localparam int QTR_BITS  = 14;
   localparam int ANGLE_W   = 16;
   localparam int DIST_W    = 18;
   localparam int RADIUS_W  = 15;
   localparam int MAP_W     = 16;
   localparam int MAG_W     = 17;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(5000);

   // polynomial datapath in Q30
   localparam int Q_FRAC = 30;
   localparam int Q_W    = 31;

   // odd taylor coefficients of sin(pi/2 * t), highest order first, Q30
   localparam int N_COEF = 5;
   localparam logic [Q_W-1:0] SINE_C11 = Q_W'(3864);
   localparam logic [Q_W-1:0] SINE_COEF [N_COEF] = '{
      Q_W'(172272),
      Q_W'(5026995),
      Q_W'(85569306),
      Q_W'(693598668),
      Q_W'(1686629713)
   };

   // square stage, coefficient stages, final product, rounding
   localparam int SINE_LATENCY = N_COEF + 3;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]  distance;
      logic               reject;
   } item_type;

endpackage

>>> sv/lp2m_quarter_sine.sv
// pipelined quarter-wave sine, one phase per cycle while enable is high
module lp2m_quarter_sine #(
   parameter int TRIG_FRAC_BITS = lp2m_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [lp2m_pkg::QTR_BITS:0] phi,
   output logic [TRIG_FRAC_BITS:0]     trig
);
   import lp2m_pkg::*;

   localparam int RND_SH = Q_FRAC - TRIG_FRAC_BITS;
   localparam int RND_W  = Q_W + 1;
   localparam int SUM_W  = RND_W - RND_SH;
   localparam logic [TRIG_FRAC_BITS:0] ONE = (TRIG_FRAC_BITS + 1)'(1) << TRIG_FRAC_BITS;

   logic [Q_W-1:0]   t30_in;
   logic [2*Q_W-1:0] sq_prod;
   logic [Q_W-1:0]   t30_ff [0:N_COEF];
   logic [Q_W-1:0]   t2_ff  [0:N_COEF-1];
   logic [Q_W-1:0]   p_ff   [0:N_COEF-1];
   logic [Q_W-1:0]   p_in   [0:N_COEF-1];
   logic [2*Q_W-1:0] p_prod [0:N_COEF-1];
   logic [2*Q_W-1:0] s_prod;
   logic [Q_W-1:0]   s_ff;
   logic [Q_W-1:0]   s_in;
   logic [RND_W-1:0] rnd;
   logic [SUM_W-1:0] rnd_shift;
   logic [TRIG_FRAC_BITS:0] trig_ff;
   logic [TRIG_FRAC_BITS:0] trig_in;

   // t = phi / 16384 in Q30
   assign t30_in  = {phi, {(Q_FRAC - QTR_BITS){1'b0}}};
   assign sq_prod = t30_in * t30_in;

   // horner steps, one multiply per stage
   for (genvar k = 0; k < N_COEF; k++) begin : g_horner
      if (k == 0) begin : g_first
         assign p_prod[k] = t2_ff[k] * SINE_C11;
      end else begin : g_next
         assign p_prod[k] = t2_ff[k] * p_ff[k-1];
      end
      assign p_in[k] = SINE_COEF[k] - p_prod[k][Q_FRAC +: Q_W];
   end

   assign s_prod = t30_ff[N_COEF] * p_ff[N_COEF-1];
   assign s_in   = s_prod[Q_FRAC +: Q_W];

   // round half up, then clamp at 1.0
   always_comb begin
      rnd       = {1'b0, s_ff} + (RND_W'(1) << (RND_SH - 1));
      rnd_shift = rnd[RND_W-1:RND_SH];
      if (rnd_shift > SUM_W'(ONE)) begin
         trig_in = ONE;
      end else begin
         trig_in = rnd_shift[TRIG_FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t30_ff[0] <= t30_in;
         t2_ff[0]  <= sq_prod[Q_FRAC +: Q_W];
         for (int k = 1; k <= N_COEF; k++) begin
            t30_ff[k] <= t30_ff[k-1];
         end
         for (int k = 1; k < N_COEF; k++) begin
            t2_ff[k] <= t2_ff[k-1];
         end
         for (int k = 0; k < N_COEF; k++) begin
            p_ff[k] <= p_in[k];
         end
         s_ff    <= s_in;
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

>>> sv/lidar_polar_to_map_xy.sv
// lidar polar measurement to map xy conversion, top level
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_angle_q14, req_distance_q2
//   rsp       out        rsp_valid / rsp_ready   rsp_point_valid, rsp_map_x, rsp_map_y,
//                                                rsp_angle_out, rsp_distance_out
//   csr       in         csr_wr_en               csr_wr_data (scan radius, mm)
//
// one request per cycle while rsp is not stalled; each passes from acceptance to
// rsp_valid through the input register, the sine/cosine polynomial pipeline,
// the distance multiply and the output register.
// reset clears all stage valids and loads the scan radius with 5000.
// the whole pipeline advances together whenever the output register is empty or
// being taken; a stalled rsp holds every stage and drops req_ready.
module lidar_polar_to_map_xy #(
   parameter int TRIG_FRAC_BITS = lp2m_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lp2m_pkg::ANGLE_W-1:0]    req_angle_q14,
   input  logic [lp2m_pkg::DIST_W-1:0]     req_distance_q2,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_point_valid,
   output logic [lp2m_pkg::MAP_W-1:0]      rsp_map_x,
   output logic [lp2m_pkg::MAP_W-1:0]      rsp_map_y,
   output logic [lp2m_pkg::ANGLE_W-1:0]    rsp_angle_out,
   output logic [lp2m_pkg::DIST_W-1:0]     rsp_distance_out,
   input  logic                            csr_wr_en,
   input  logic [lp2m_pkg::RADIUS_W-1:0]   csr_wr_data
);
   import lp2m_pkg::*;

   localparam int TRIG_W = TRIG_FRAC_BITS + 1;
   localparam int PROD_W = DIST_W + TRIG_W;
   localparam int M_SH   = TRIG_FRAC_BITS + 2;
   localparam int LAT    = SINE_LATENCY;
   localparam int XY_W   = MAP_W + 2;

   logic                   advance;
   logic [RADIUS_W-1:0]    radius_ff;
   logic                   vld_ff  [0:LAT];
   item_type               pipe_ff [0:LAT];
   item_type               pipe_in;
   logic [QTR_BITS:0]      sin_phi;
   logic [QTR_BITS:0]      cos_phi;
   logic [TRIG_W-1:0]      sin_val;
   logic [TRIG_W-1:0]      cos_val;
   logic [PROD_W-1:0]      ms_prod;
   logic [PROD_W-1:0]      mc_prod;
   logic                   mul_vld_ff;
   item_type               mul_item_ff;
   logic [MAG_W-1:0]       ms_ff;
   logic [MAG_W-1:0]       mc_ff;
   logic [1:0]             quad;
   logic [MAG_W-1:0]       mx;
   logic [MAG_W-1:0]       my;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic                   ok_in;
   logic                   rsp_valid_ff;
   logic                   ok_ff;
   logic [MAP_W-1:0]       map_x_ff;
   logic [MAP_W-1:0]       map_y_ff;
   logic [ANGLE_W-1:0]     angle_ff;
   logic [DIST_W-1:0]      dist_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   // entry range check; keep radius steady while requests are in flight (unchecked)
   always_comb begin
      pipe_in.angle    = req_angle_q14;
      pipe_in.distance = req_distance_q2;
      pipe_in.reject   = (req_distance_q2 == '0) ||
                         (req_distance_q2 > {1'b0, radius_ff, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         mul_vld_ff   <= vld_ff[LAT];
         rsp_valid_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= pipe_in;
         for (int k = 1; k <= LAT; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   // cosine is the sine of the complementary phase
   assign sin_phi = {1'b0, pipe_ff[0].angle[QTR_BITS-1:0]};
   assign cos_phi = (QTR_BITS + 1)'(1 << QTR_BITS) - sin_phi;

   lp2m_quarter_sine #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_sine (
      .clock  (clock),
      .enable (advance),
      .phi    (sin_phi),
      .trig   (sin_val)
   );

   lp2m_quarter_sine #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_cosine (
      .clock  (clock),
      .enable (advance),
      .phi    (cos_phi),
      .trig   (cos_val)
   );

   assign ms_prod = pipe_ff[LAT].distance * sin_val;
   assign mc_prod = pipe_ff[LAT].distance * cos_val;

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_item_ff <= pipe_ff[LAT];
         ms_ff       <= ms_prod[M_SH +: MAG_W];
         mc_ff       <= mc_prod[M_SH +: MAG_W];
      end
   end

   // quadrant selects which magnitude goes to which axis and the signs
   always_comb begin
      quad = mul_item_ff.angle[ANGLE_W-1 -: 2];
      mx   = quad[0] ? mc_ff : ms_ff;
      my   = quad[0] ? ms_ff : mc_ff;
      if (!quad[1]) begin
         xs = XY_W'(radius_ff) + XY_W'(mx);
      end else begin
         xs = XY_W'(radius_ff) - XY_W'(mx);
      end
      if (quad[1] ^ quad[0]) begin
         ys = XY_W'(radius_ff) + XY_W'(my);
      end else begin
         ys = XY_W'(radius_ff) - XY_W'(my);
      end
      ok_in = !mul_item_ff.reject && !(xs == '0 && ys == '0) &&
              !xs[XY_W-1] && !ys[XY_W-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_ff    <= ok_in;
         map_x_ff <= ok_in ? xs[MAP_W-1:0] : '0;
         map_y_ff <= ok_in ? ys[MAP_W-1:0] : '0;
         angle_ff <= mul_item_ff.angle;
         dist_ff  <= mul_item_ff.distance;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_valid  = ok_ff;
   assign rsp_map_x        = map_x_ff;
   assign rsp_map_y        = map_y_ff;
   assign rsp_angle_out    = angle_ff;
   assign rsp_distance_out = dist_ff;

   // accepted points lie inside the square of side twice the radius
   a_inside_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_valid |->
         rsp_map_x <= {radius_ff, 1'b0} && rsp_map_y <= {radius_ff, 1'b0})
      else $error("accepted point outside map");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |-> rsp_map_x == '0 && rsp_map_y == '0)
      else $error("rejected point with nonzero coordinates");

   a_range_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_valid |->
         rsp_distance_out != '0 && rsp_distance_out <= {1'b0, radius_ff, 2'b00})
      else $error("out of range distance accepted");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
